[src/offt_pkg.sv]
`default_nettype none

package offt_pkg;

  localparam int unsigned MAX_VERTS = 65536;
  localparam int unsigned IDX_W     = $clog2(MAX_VERTS + 1);
  localparam int unsigned NUM_W     = $clog2(MAX_VERTS + 2);
  localparam int unsigned ACC_W     = NUM_W + 4;
  localparam int unsigned OUT_W     = 16;

  localparam logic [IDX_W-1:0] BAD_MARK = IDX_W'(MAX_VERTS);
  localparam logic [NUM_W-1:0] NUM_CAP  = NUM_W'(MAX_VERTS + 1);

  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    POS_START  = 2'd0,
    POS_SECOND = 2'd1,
    POS_REST   = 2'd2
  } pos_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_V_SEEN = 2'd1,
    KIND_F_SEEN = 2'd2,
    KIND_FACE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_HELD   = 2'd3
  } phase_e;

  typedef struct packed {
    pos_e             pos;
    kind_e            kind;
    logic             prev_sp;
    phase_e           phase;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [1:0]       fvc;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] prev;
    logic [IDX_W-1:0] vcnt;
  } st_t;

  typedef struct packed {
    logic             valid;
    logic [OUT_W-1:0] first;
    logic [OUT_W-1:0] prev;
    logic [OUT_W-1:0] curr;
    logic             bad;
  } res_t;

  typedef struct packed {
    st_t  s;
    res_t r;
  } step_t;

  localparam st_t RESET_ST = '{
    pos:     POS_START,
    kind:    KIND_NONE,
    prev_sp: 1'b1,
    phase:   PH_IDLE,
    neg:     1'b0,
    num:     '0,
    fvc:     2'd0,
    first:   '0,
    prev:    '0,
    vcnt:    '0
  };

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic [NUM_W-1:0] accumulate(input logic [NUM_W-1:0] num,
                                                   input logic [7:0] b);
    logic [ACC_W-1:0] v;
    v = ACC_W'(num) * ACC_W'(10) + ACC_W'(b - CH_ZERO);
    return (v > ACC_W'(NUM_CAP)) ? NUM_CAP : NUM_W'(v);
  endfunction

  function automatic logic [IDX_W-1:0] resolve(input st_t s);
    logic [IDX_W-1:0] idx;
    if (s.num == '0) begin
      idx = BAD_MARK;
    end else if (!s.neg) begin
      idx = (s.num > NUM_W'(MAX_VERTS)) ? BAD_MARK : IDX_W'(s.num - NUM_W'(1));
    end else if (s.num > NUM_W'(s.vcnt)) begin
      idx = BAD_MARK;
    end else begin
      idx = s.vcnt - IDX_W'(s.num);
    end
    return idx;
  endfunction

  function automatic logic [OUT_W-1:0] out_index(input logic [IDX_W-1:0] x);
    return (x >= BAD_MARK) ? '0 : OUT_W'(x);
  endfunction

  function automatic step_t close_token(input st_t s);
    step_t            o;
    logic [IDX_W-1:0] idx;
    o.s = s;
    o.r = '0;
    idx = resolve(s);
    if (s.phase == PH_DIGITS || s.phase == PH_HELD) begin
      unique case (s.fvc)
        2'd0: begin
          o.s.first = idx;
          o.s.fvc   = 2'd1;
        end
        2'd1: begin
          o.s.prev = idx;
          o.s.fvc  = 2'd2;
        end
        default: begin
          o.r.valid = 1'b1;
          o.r.first = out_index(s.first);
          o.r.prev  = out_index(s.prev);
          o.r.curr  = out_index(idx);
          o.r.bad   = (s.first >= BAD_MARK) || (s.prev >= BAD_MARK) || (idx >= BAD_MARK);
          o.s.prev  = idx;
        end
      endcase
    end
    o.s.phase = PH_IDLE;
    o.s.neg   = 1'b0;
    o.s.num   = '0;
    return o;
  endfunction

endpackage

`default_nettype wire

[src/obj_face_fan_triangulator_unit.sv]
// A result appears on the output register in the cycle after the byte that closes it.
// Throughput: one byte per cycle while stall_o is low; the per-byte state update is one registered pass.
// The output register holds a result while stalled; a new byte is taken whenever
// that register is empty or draining in the same cycle.
// Reset: asynchronous, active low; parser state returns to line start, counters clear.
`default_nettype none

module obj_face_fan_triangulator_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output logic                           stall_o,
  input  wire logic [7:0]                text_byte_i,
  input  wire logic                      last_byte_i,
  output logic                           valid_o,
  input  wire logic                      stall_i,
  output logic [offt_pkg::OUT_W-1:0]     index_first_o,
  output logic [offt_pkg::OUT_W-1:0]     index_prev_o,
  output logic [offt_pkg::OUT_W-1:0]     index_curr_o,
  output logic                           bad_index_o
);
  import offt_pkg::*;

  st_t   st_q, st_d;
  res_t  res_d;
  step_t cl;
  logic  accept;
  logic  out_valid_q;
  res_t  out_q;

  assign stall_o = out_valid_q & stall_i;
  assign accept  = valid_i & ~stall_o;

  always_comb begin
    st_d  = st_q;
    res_d = '0;
    cl    = '0;
    if (st_q.kind == KIND_FACE) begin
      if (text_byte_i == CH_SPACE || text_byte_i == CH_NL) begin
        cl    = close_token(st_d);
        st_d  = cl.s;
        res_d = cl.r;
        if (text_byte_i == CH_SPACE) begin
          st_d.prev_sp = 1'b1;
        end
      end else begin
        if (st_q.prev_sp) begin
          st_d.neg = 1'b0;
          st_d.num = '0;
          if (is_digit(text_byte_i)) begin
            st_d.phase = PH_DIGITS;
            st_d.num   = accumulate('0, text_byte_i);
          end else if (text_byte_i == CH_MINUS || text_byte_i == CH_PLUS) begin
            st_d.phase = PH_SIGN;
            st_d.neg   = (text_byte_i == CH_MINUS);
          end else begin
            st_d.phase = PH_IDLE;
          end
        end else if (st_q.phase == PH_SIGN) begin
          if (is_digit(text_byte_i)) begin
            st_d.phase = PH_DIGITS;
            st_d.num   = accumulate(st_q.num, text_byte_i);
          end else begin
            st_d.phase = PH_IDLE;
          end
        end else if (st_q.phase == PH_DIGITS) begin
          if (is_digit(text_byte_i)) begin
            st_d.num = accumulate(st_q.num, text_byte_i);
          end else begin
            st_d.phase = PH_HELD;
          end
        end
        st_d.prev_sp = 1'b0;
      end
    end else if (st_q.pos == POS_START) begin
      if (text_byte_i == CH_V) begin
        st_d.kind = KIND_V_SEEN;
      end else if (text_byte_i == CH_F) begin
        st_d.kind = KIND_F_SEEN;
      end else begin
        st_d.kind = KIND_NONE;
      end
    end else if (st_q.pos == POS_SECOND) begin
      if (text_byte_i == CH_SPACE && st_q.kind == KIND_V_SEEN) begin
        if (st_q.vcnt < IDX_W'(MAX_VERTS)) begin
          st_d.vcnt = st_q.vcnt + IDX_W'(1);
        end
        st_d.kind = KIND_NONE;
      end else if (text_byte_i == CH_SPACE && st_q.kind == KIND_F_SEEN) begin
        st_d.kind    = KIND_FACE;
        st_d.prev_sp = 1'b1;
        st_d.phase   = PH_IDLE;
        st_d.neg     = 1'b0;
        st_d.num     = '0;
        st_d.fvc     = 2'd0;
      end else begin
        st_d.kind = KIND_NONE;
      end
    end

    if (text_byte_i == CH_NL) begin
      st_d.pos     = POS_START;
      st_d.kind    = KIND_NONE;
      st_d.prev_sp = 1'b1;
      st_d.phase   = PH_IDLE;
      st_d.fvc     = 2'd0;
    end else if (st_q.pos == POS_START) begin
      st_d.pos = POS_SECOND;
    end else if (st_q.pos == POS_SECOND) begin
      st_d.pos = POS_REST;
    end

    if (last_byte_i) begin
      if (!res_d.valid && st_d.kind == KIND_FACE) begin
        cl    = close_token(st_d);
        res_d = cl.r;
      end
      st_d = RESET_ST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= RESET_ST;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        st_q <= st_d;
      end
      if (!out_valid_q || !stall_i) begin
        out_valid_q <= accept & res_d.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!out_valid_q || !stall_i) && accept && res_d.valid) begin
      out_q <= res_d;
    end
  end

  assign valid_o       = out_valid_q;
  assign index_first_o = out_q.first;
  assign index_prev_o  = out_q.prev;
  assign index_curr_o  = out_q.curr;
  assign bad_index_o   = out_q.bad;

endmodule

`default_nettype wire

[src/offt_chk.sv]
`default_nettype none

module offt_chk (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  valid_i,
  input wire logic                  stall_o,
  input wire logic [7:0]            text_byte_i,
  input wire logic                  last_byte_i,
  input wire logic                  valid_o,
  input wire logic                  stall_i,
  input wire logic [offt_pkg::OUT_W-1:0] index_first_o,
  input wire logic [offt_pkg::OUT_W-1:0] index_prev_o,
  input wire logic [offt_pkg::OUT_W-1:0] index_curr_o,
  input wire logic                  bad_index_o
);
  import offt_pkg::*;

  // held result stays put while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(index_first_o) && $stable(index_prev_o)
      && $stable(index_curr_o) && $stable(bad_index_o))
    else $error("stalled result changed");

  // input is only held back by a stalled, occupied output register
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without a pending result");

  // a new result follows a transfer of a token-closing byte
  a_new_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !($past(valid_o) && $past(stall_i)) |->
      $past(valid_i) && !$past(stall_o) &&
      ($past(text_byte_i) == CH_SPACE || $past(text_byte_i) == CH_NL || $past(last_byte_i)))
    else $error("result without a closing byte");

endmodule

bind obj_face_fan_triangulator_unit offt_chk u_offt_chk (.*);

`default_nettype wire

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import offt_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] first;
    logic [OUT_W-1:0] prev;
    logic [OUT_W-1:0] curr;
    logic             bad;
  } tri_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             valid_i     = 1'b0;
  logic             stall_i     = 1'b0;
  logic [7:0]       text_byte_i = 8'h00;
  logic             last_byte_i = 1'b0;
  logic             stall_o;
  logic             valid_o;
  logic [OUT_W-1:0] index_first_o;
  logic [OUT_W-1:0] index_prev_o;
  logic [OUT_W-1:0] index_curr_o;
  logic             bad_index_o;

  obj_face_fan_triangulator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .text_byte_i   (text_byte_i),
    .last_byte_i   (last_byte_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .index_first_o (index_first_o),
    .index_prev_o  (index_prev_o),
    .index_curr_o  (index_curr_o),
    .bad_index_o   (bad_index_o)
  );

  always #5 clk_i = ~clk_i;

  // parser shadow state
  pos_e             sh_pos;
  kind_e            sh_kind;
  bit               sh_prev_sp;
  phase_e           sh_phase;
  bit               sh_neg;
  logic [NUM_W-1:0] sh_num;
  logic [1:0]       sh_fvc;
  logic [IDX_W-1:0] sh_first;
  logic [IDX_W-1:0] sh_prev;
  logic [IDX_W-1:0] sh_vcnt;

  tri_t pending_tris[$];
  int   n_errors   = 0;
  int   n_tris     = 0;
  int   n_bad_tris = 0;
  int   bytes_sent = 0;
  bit   quiet      = 1'b0;
  int   stall_hold = 0;

  task automatic clear_parser();
    sh_pos     = POS_START;
    sh_kind    = KIND_NONE;
    sh_prev_sp = 1'b1;
    sh_phase   = PH_IDLE;
    sh_neg     = 1'b0;
    sh_num     = '0;
    sh_fvc     = 2'd0;
    sh_first   = '0;
    sh_prev    = '0;
    sh_vcnt    = '0;
  endtask

  function automatic bit digit_char(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  task automatic add_digit(input logic [7:0] b);
    int v;
    v = int'(sh_num) * 10 + int'(b) - int'(CH_ZERO);
    sh_num = (v > MAX_VERTS + 1) ? NUM_W'(MAX_VERTS + 1) : NUM_W'(v);
  endtask

  function automatic logic [IDX_W-1:0] token_vertex();
    if (sh_num == 0) return BAD_MARK;
    if (!sh_neg) return (sh_num > MAX_VERTS) ? BAD_MARK : IDX_W'(sh_num - 1);
    if (sh_num > sh_vcnt) return BAD_MARK;
    return sh_vcnt - IDX_W'(sh_num);
  endfunction

  function automatic logic [OUT_W-1:0] shown_index(input logic [IDX_W-1:0] x);
    return (x >= BAD_MARK) ? '0 : x[OUT_W-1:0];
  endfunction

  task automatic close_field(output bit hit, output tri_t t);
    logic [IDX_W-1:0] idx;
    hit = 1'b0;
    t   = '0;
    if (sh_phase == PH_DIGITS || sh_phase == PH_HELD) begin
      idx = token_vertex();
      if (sh_fvc == 2'd0) begin
        sh_first = idx;
        sh_fvc   = 2'd1;
      end else if (sh_fvc == 2'd1) begin
        sh_prev = idx;
        sh_fvc  = 2'd2;
      end else begin
        hit     = 1'b1;
        t.first = shown_index(sh_first);
        t.prev  = shown_index(sh_prev);
        t.curr  = shown_index(idx);
        t.bad   = sh_first >= BAD_MARK || sh_prev >= BAD_MARK || idx >= BAD_MARK;
        sh_prev = idx;
      end
    end
    sh_phase = PH_IDLE;
    sh_neg   = 1'b0;
    sh_num   = '0;
  endtask

  task automatic token_byte(input logic [7:0] b);
    if (sh_prev_sp) begin
      sh_neg = 1'b0;
      sh_num = '0;
      if (digit_char(b)) begin
        sh_phase = PH_DIGITS;
        add_digit(b);
      end else if (b == CH_MINUS || b == CH_PLUS) begin
        sh_phase = PH_SIGN;
        sh_neg   = (b == CH_MINUS);
      end else begin
        sh_phase = PH_IDLE;
      end
    end else if (sh_phase == PH_SIGN) begin
      if (digit_char(b)) begin
        sh_phase = PH_DIGITS;
        add_digit(b);
      end else begin
        sh_phase = PH_IDLE;
      end
    end else if (sh_phase == PH_DIGITS) begin
      if (digit_char(b)) add_digit(b);
      else sh_phase = PH_HELD;
    end
    sh_prev_sp = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input bit last, output bit hit,
                            output tri_t t);
    hit = 1'b0;
    t   = '0;
    if (sh_kind == KIND_FACE) begin
      if (b == CH_SPACE) begin
        close_field(hit, t);
        sh_prev_sp = 1'b1;
      end else if (b == CH_NL) begin
        close_field(hit, t);
      end else begin
        token_byte(b);
      end
    end else if (sh_pos == POS_START) begin
      if (b == CH_V) sh_kind = KIND_V_SEEN;
      else if (b == CH_F) sh_kind = KIND_F_SEEN;
      else sh_kind = KIND_NONE;
    end else if (sh_pos == POS_SECOND) begin
      if (b == CH_SPACE && sh_kind == KIND_V_SEEN) begin
        if (sh_vcnt < MAX_VERTS) sh_vcnt = sh_vcnt + 1'b1;
        sh_kind = KIND_NONE;
      end else if (b == CH_SPACE && sh_kind == KIND_F_SEEN) begin
        sh_kind    = KIND_FACE;
        sh_prev_sp = 1'b1;
        sh_phase   = PH_IDLE;
        sh_neg     = 1'b0;
        sh_num     = '0;
        sh_fvc     = 2'd0;
      end else begin
        sh_kind = KIND_NONE;
      end
    end
    if (b == CH_NL) begin
      sh_pos     = POS_START;
      sh_kind    = KIND_NONE;
      sh_prev_sp = 1'b1;
      sh_phase   = PH_IDLE;
      sh_fvc     = 2'd0;
    end else if (sh_pos != POS_REST) begin
      sh_pos = pos_e'(sh_pos + 2'd1);
    end
    if (last) begin
      if (!hit && sh_kind == KIND_FACE) close_field(hit, t);
      clear_parser();
    end
  endtask

  initial clear_parser();

  // transfer monitor: check results, then predict from the accepted byte
  always @(posedge clk_i) begin
    bit   hit;
    tri_t want;
    tri_t got;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        got = '{index_first_o, index_prev_o, index_curr_o, bad_index_o};
        if (pending_tris.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected triangle first=%0d prev=%0d curr=%0d bad=%0b",
                   $time, got.first, got.prev, got.curr, got.bad);
        end else begin
          want = pending_tris.pop_front();
          if (got !== want) begin
            n_errors++;
            $display("%0t: triangle mismatch: expected first=%0d prev=%0d curr=%0d bad=%0b",
                     $time, want.first, want.prev, want.curr, want.bad);
            $display("%0t:                    actual   first=%0d prev=%0d curr=%0d bad=%0b",
                     $time, got.first, got.prev, got.curr, got.bad);
          end
        end
      end
      if (valid_i && !stall_o) begin
        parse_byte(text_byte_i, last_byte_i, hit, want);
        if (hit) begin
          pending_tris.push_back(want);
          n_tris++;
          if (want.bad) n_bad_tris++;
        end
      end
    end
  end

  // mostly short idle stretches, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  always @(negedge clk_i) begin
    if (quiet) begin
      stall_i    <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else if (stall_i) begin
      stall_i    <= 1'b0;
      stall_hold = $urandom_range(0, 8);
    end else if ($urandom_range(0, 2) == 0) begin
      stall_i    <= 1'b1;
      stall_hold = idle_len() - 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i     <= 1'b1;
    text_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (stall_o);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last_at_end && i == s.len() - 1);
  endtask

  task automatic drain();
    @(negedge clk_i);
    valid_i <= 1'b0;
    while (pending_tris.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic test_fan_faces();
    send_text("v 1 2 3\nv \nv \nv \n", 0);
    send_text("f 1 2 3 4\n", 0);
    send_text("f -1 -2 -4\n", 0);
    send_text("f 1/2/3 2//5 3/1 4\r\n", 0);
  endtask

  task automatic test_bad_indices();
    send_text("f 0 -0 65536 65537 99999999 -5 4\n", 0);
    send_text("f +0 2 -4 1\n", 0);
  endtask

  task automatic test_numberless_tokens();
    send_text("f + 1 -x a 2  +3 3a\t\r -/2 4\n", 0);
  endtask

  task automatic test_line_kinds();
    send_text("vt 1\n fx\nf\tx\n f 1 2 3\nff 1 2 3\nv\nvv \n\n", 0);
    send_text("v \nf 1", 0);
    send_byte(8'h00, 0);
    send_text(" 2", 0);
    send_byte(8'hFF, 0);
    send_text(" 3\n", 0);
  endtask

  task automatic test_last_byte();
    send_text("f 1 2 3", 1);
    send_text("f 1 2 -1 4 ", 1);
    send_text("v \nv \nf 1 2 2\n", 1);
    send_text("f -1 1 2 3", 0);
    send_byte(8'hA5, 1);
  endtask

  function automatic string face_token();
    int    r;
    int    span;
    string s;
    span = (sh_vcnt > 40) ? 40 : int'(sh_vcnt) + 2;
    r = $urandom_range(0, 99);
    if (r < 45) s = $sformatf("%0d", $urandom_range(1, span));
    else if (r < 70) s = $sformatf("-%0d", $urandom_range(1, span));
    else if (r < 76) s = $sformatf("+%0d", $urandom_range(1, span));
    else if (r < 80) s = $sformatf("%0d", $urandom_range(65530, 65540));
    else if (r < 83) s = $sformatf("%0d", $urandom_range(100000, 99999999));
    else if (r < 86) s = ($urandom_range(0, 1) == 0) ? string'("0") : string'("-0");
    else if (r < 91) s = ($urandom_range(0, 1) == 0) ? string'("-") : string'("+/2");
    else if (r < 95) s = "x1";
    else s = $sformatf("00%0d", $urandom_range(1, span));
    if ($urandom_range(0, 4) == 0) s = {s, $sformatf("/%0d/%0d", $urandom_range(0, 9),
                                                     $urandom_range(0, 9))};
    else if ($urandom_range(0, 9) == 0) s = {s, "//7"};
    return s;
  endfunction

  task automatic random_face(input bit last_at_end);
    string s;
    int    n;
    s = "f";
    n = $urandom_range(1, 7);
    for (int k = 0; k < n; k++) begin
      s = {s, ($urandom_range(0, 7) == 0) ? string'("  ") : string'(" "), face_token()};
    end
    if (last_at_end) begin
      if ($urandom_range(0, 2) == 0) s = {s, " "};
      send_text(s, 1);
    end else begin
      send_text({s, ($urandom_range(0, 5) == 0) ? string'("\r\n") : string'("\n")}, 0);
    end
  endtask

  task automatic test_random_files();
    int start_bytes;
    int r;
    int len;
    bit drained;
    start_bytes = bytes_sent;
    drained     = 1'b0;
    while (bytes_sent - start_bytes < 720) begin
      if ($urandom_range(0, 19) == 0) quiet = ~quiet;
      if (!drained && bytes_sent - start_bytes > 360) begin
        drain();
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_text(($urandom_range(0, 1) == 0) ? string'("v \n") : string'("v 0.5 1 -2\n"), 0);
      end else if (r < 75) begin
        random_face(0);
      end else if (r < 85) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), 0);
        send_byte(CH_NL, 0);
      end else if (r < 95) begin
        case ($urandom_range(0, 4))
          0: send_text("vx 1\n", 0);
          1: send_text(" f 1 2 3\n", 0);
          2: send_text("f\n", 0);
          3: send_text("fv 1 2 3\n", 0);
          default: send_text("\n", 0);
        endcase
      end else if (r < 98) begin
        random_face(1);
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_fan_faces();
    test_bad_indices();
    test_numberless_tokens();
    test_line_kinds();
    test_last_byte();
    drain();
    test_random_files();
    drain();
    $display("Sent %0d bytes: vertex and face lines, numberless and out-of-range tokens,",
             bytes_sent);
    $display("end-of-file resets and number saturation; %0d triangles checked, %0d flagged bad.",
             n_tris, n_bad_tris);
    if (n_errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #4ms;
    $display("Timeout with %0d triangles still pending", pending_tris.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
